FILE: rtl/core/bsps_pkg.sv
// Shared types and constants for the bit sync pattern search block.
`default_nettype none

package bsps_pkg;

    localparam int LANES         = 8;
    localparam int LANE_IDX_BITS = 3;
    localparam int LEN_BITS      = 7;
    localparam int CNT_BITS      = 4;

    // record kinds
    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_SPAN    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // summary status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DATA   = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;

    localparam logic [LEN_BITS-1:0] LENGTH_RESET = 7'd16;

    // pending work of one merged item
    typedef struct packed {
        logic [LANES-1:0] emask;   // lanes with a record to send
        logic             span;    // closing frame span pending
        logic             summ;    // summary pending
        logic [2:0]       status;  // summary status
    } batch_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bit_sync_pattern_search_top.sv
// Top level of the bit sync pattern search: config registers, bit window, lanes, merge, output.
`default_nettype none

// Searches a byte stream (bit 7 of each byte first) for a sync pattern of 1 to
// PATTERN_MAX_BITS bits at every bit offset. Eight comparator lanes test the
// eight bit offsets of each byte at once against a window of the previous bits;
// a merge stage then applies bit positions, the frame-mode holdoff and the match
// count, and an output buffer sends the resulting records one per cycle.
// An item carrying a byte enters every cycle as long as it yields at most one
// record and out_stall is low; an item that yields n records sends them one at
// a time, and the input side stalls while those drain. Taking an item loads
// the input stage; its records then go from the merge into the result buffer,
// then into the output register.
// In overlap mode (search_mode 0) each match gives a match-start record. In
// frame mode each match after the first gives the span of the previous frame,
// and start positions within pattern_length-1 bits after a match are skipped.
// An item with end_of_data closes the stream: frame mode sends any final span,
// then a summary record with match count, first match and status, and all
// stream state (window included) returns to its reset value. pattern_length 0
// acts as 1, values above PATTERN_MAX_BITS act as PATTERN_MAX_BITS. Once the
// position counter reaches its maximum, further bits are neither counted nor
// searched and the summary reports overflow. Configuration should be written
// only while no item is in flight.
module bit_sync_pattern_search_top #(
    parameter int PATTERN_MAX_BITS = 64,
    parameter int POSITION_BITS    = 36
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     cfg_wr_en,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [63:0]              cfg_data,
    // input channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     byte_valid,
    input  wire logic                     end_of_data,
    // output channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    record_kind,
    output logic [POSITION_BITS-1:0]      start_bit,
    output logic [POSITION_BITS-1:0]      length_bits,
    output logic [POSITION_BITS-1:0]      match_count,
    output logic [2:0]                    status,
    output logic                          last
);

    import bsps_pkg::*;

    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(PATTERN_MAX_BITS);

    // configuration registers
    logic [PATTERN_MAX_BITS-1:0] pattern_reg, pattern_next;
    logic [LEN_BITS-1:0]         plen_reg,    plen_next;
    logic                        mode_reg,    mode_next;

    // stream window, before the current byte
    logic [PATTERN_MAX_BITS-1:0] window_reg,  window_next;
    logic [PATTERN_MAX_BITS+7:0] shifted;

    // input stage: raw lane hits plus flags
    logic             s1_valid_reg, s1_valid_next;
    logic [LANES-1:0] s1_hit_reg;
    logic             s1_bvalid_reg;
    logic             s1_eod_reg;

    logic [LEN_BITS-1:0]         used_len;
    logic [PATTERN_MAX_BITS-1:0] len_mask;
    logic [LANES-1:0]            raw_hit;
    logic                        accept;
    logic                        advance;

    batch_ctrl_t                         ctrl;
    logic [LANES-1:0][POSITION_BITS-1:0] lane_start;
    logic [LANES-1:0][POSITION_BITS-1:0] lane_prev;
    logic [LANES-1:0][POSITION_BITS-1:0] lane_cnt;
    logic [POSITION_BITS-1:0]            span_start;
    logic [POSITION_BITS-1:0]            span_len;
    logic [POSITION_BITS-1:0]            fin_cnt;
    logic [POSITION_BITS-1:0]            summ_start;
    logic [POSITION_BITS-1:0]            summ_len;

    // ---------------- configuration ----------------
    always_comb
    begin
        pattern_next = pattern_reg;
        plen_next    = plen_reg;
        mode_next    = mode_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN: pattern_next = cfg_data[PATTERN_MAX_BITS-1:0];
                REG_LENGTH:  plen_next    = cfg_data[LEN_BITS-1:0];
                REG_MODE:    mode_next    = cfg_data[0];
                default:     ;  // no register here
            endcase
        end
    end

    // effective length and compare mask
    always_comb
    begin
        if (plen_reg == '0)
        begin
            used_len = LEN_BITS'(1);
        end
        else if (plen_reg > MAX_LEN)
        begin
            used_len = MAX_LEN;
        end
        else
        begin
            used_len = plen_reg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < PATTERN_MAX_BITS; j++)
        begin : g_mask
            assign len_mask[j] = LEN_BITS'(j) < used_len;
        end
    endgenerate

    // ---------------- input stage and window ----------------
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign shifted  = {window_reg, data_byte};

    always_comb
    begin
        window_next = window_reg;
        if (accept)
        begin
            if (end_of_data)
            begin
                window_next = '0;
            end
            else if (byte_valid)
            begin
                window_next = shifted[PATTERN_MAX_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // one comparator per bit offset of the byte
    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            bsps_lane #(
                .PATTERN_MAX_BITS (PATTERN_MAX_BITS),
                .OFFSET           (g)
            ) u_lane (
                .window    (window_reg),
                .data_byte (data_byte),
                .pattern   (pattern_reg),
                .mask      (len_mask),
                .raw_hit   (raw_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_reg     <= LENGTH_RESET;
            mode_reg     <= 1'b0;
            window_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg  <= pattern_next;
            plen_reg     <= plen_next;
            mode_reg     <= mode_next;
            window_reg   <= window_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg    <= raw_hit;
            s1_bvalid_reg <= byte_valid;
            s1_eod_reg    <= end_of_data;
        end
    end

    // ---------------- merge across lanes ----------------
    bsps_merge #(
        .POSITION_BITS (POSITION_BITS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .raw_hit     (s1_hit_reg),
        .byte_valid  (s1_bvalid_reg),
        .end_of_data (s1_eod_reg),
        .used_len    (used_len),
        .mode        (mode_reg),
        .ctrl        (ctrl),
        .lane_start  (lane_start),
        .lane_prev   (lane_prev),
        .lane_cnt    (lane_cnt),
        .span_start  (span_start),
        .span_len    (span_len),
        .fin_cnt     (fin_cnt),
        .summ_start  (summ_start),
        .summ_len    (summ_len)
    );

    // ---------------- result buffer and output ----------------
    bsps_emit #(
        .POSITION_BITS (POSITION_BITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid_reg),
        .ctrl_in     (ctrl),
        .lane_start  (lane_start),
        .lane_prev   (lane_prev),
        .lane_cnt    (lane_cnt),
        .span_start  (span_start),
        .span_len    (span_len),
        .fin_cnt     (fin_cnt),
        .summ_start  (summ_start),
        .summ_len    (summ_len),
        .mode        (mode_reg),
        .used_len    (used_len),
        .out_stall   (out_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .record_kind (record_kind),
        .start_bit   (start_bit),
        .length_bits (length_bits),
        .match_count (match_count),
        .status      (status),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bsps_lane.sv
// One bit-offset comparator lane: window plus leading bits of the byte against the pattern.
`default_nettype none

module bsps_lane #(
    parameter int PATTERN_MAX_BITS = 64,
    parameter int OFFSET           = 0
) (
    input  wire logic [PATTERN_MAX_BITS-1:0] window,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [PATTERN_MAX_BITS-1:0] pattern,
    input  wire logic [PATTERN_MAX_BITS-1:0] mask,
    output logic                             raw_hit
);

    localparam int SH = 7 - OFFSET;

    logic [PATTERN_MAX_BITS+7:0] wide;
    logic [PATTERN_MAX_BITS-1:0] seg;

    assign wide    = {window, data_byte};
    assign seg     = wide[PATTERN_MAX_BITS-1+SH:SH];
    assign raw_hit = ((seg ^ pattern) & mask) == '0;

endmodule

`default_nettype wire

FILE: rtl/core/bsps_merge.sv
// Merge stage: position, holdoff and match bookkeeping across the eight lanes of one byte.
`default_nettype none

module bsps_merge #(
    parameter int POSITION_BITS = 36
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        advance,
    input  wire logic [bsps_pkg::LANES-1:0]                  raw_hit,
    input  wire logic                                        byte_valid,
    input  wire logic                                        end_of_data,
    input  wire logic [bsps_pkg::LEN_BITS-1:0]               used_len,
    input  wire logic                                        mode,
    output bsps_pkg::batch_ctrl_t                            ctrl,
    output logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0]    lane_start,
    output logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0]    lane_prev,
    output logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0]    lane_cnt,
    output logic [POSITION_BITS-1:0]                         span_start,
    output logic [POSITION_BITS-1:0]                         span_len,
    output logic [POSITION_BITS-1:0]                         fin_cnt,
    output logic [POSITION_BITS-1:0]                         summ_start,
    output logic [POSITION_BITS-1:0]                         summ_len
);

    import bsps_pkg::*;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [POSITION_BITS:0]   posx_t;

    localparam posx_t POS_MAX = posx_t'({POSITION_BITS{1'b1}});

    pos_t                bits_reg,  bits_next;
    logic                ovf_reg,   ovf_next;
    logic [LEN_BITS-1:0] hold_reg,  hold_next;
    pos_t                prev_reg,  prev_next;
    pos_t                first_reg, first_next;
    logic                found_reg, found_next;
    pos_t                cnt_reg,   cnt_next;

    logic [LANES-1:0][POSITION_BITS:0] pos;
    logic [LANES-1:0]                  counted;
    logic [LANES-1:0]                  eligible;
    logic [LANES-1:0][CNT_BITS-1:0]    nrun;
    logic [LANES-1:0]                  emask;

    logic [LEN_BITS-1:0] hold_new;
    logic                found_new;
    pos_t                prev_new;
    pos_t                first_new;
    logic [CNT_BITS-1:0] hits_total;
    logic [CNT_BITS-1:0] bits_total;
    pos_t                bits_new;
    pos_t                cnt_new;
    logic                ovf_new;
    logic [2:0]          status_new;

    // per-lane positions, all in parallel
    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_pos
            assign pos[g]        = {1'b0, bits_reg} + posx_t'(g + 1);
            assign counted[g]    = byte_valid && !ovf_reg && (pos[g] <= POS_MAX);
            assign eligible[g]   = pos[g] >= posx_t'(used_len);
            assign lane_start[g] = pos[g][POSITION_BITS-1:0] - pos_t'(used_len);
            assign lane_cnt[g]   = cnt_reg + pos_t'(nrun[g]);
        end
    endgenerate

    // holdoff runs bit by bit across the byte; narrow chain
    always_comb
    begin
        logic [LEN_BITS-1:0] h;
        logic                fa;
        pos_t                p;
        pos_t                fs;
        logic [CNT_BITS-1:0] n;
        logic [CNT_BITS-1:0] b;
        h = hold_reg;
        fa = found_reg;
        p = prev_reg;
        fs = first_reg;
        n = '0;
        b = '0;
        emask = '0;
        lane_prev = '0;
        nrun = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_prev[i] = p;
            if (counted[i])
            begin
                b = b + 1'b1;
                if (h != '0)
                begin
                    h = h - 1'b1;
                end
                else if (eligible[i] && raw_hit[i])
                begin
                    n = n + 1'b1;
                    if (mode)
                    begin
                        h = used_len - 1'b1;
                    end
                    emask[i] = !mode || fa;  // first frame start emits no span
                    if (!fa)
                    begin
                        fs = lane_start[i];
                    end
                    fa = 1'b1;
                    p = lane_start[i];
                end
            end
            nrun[i] = n;
        end
        hold_new   = h;
        found_new  = fa;
        prev_new   = p;
        first_new  = fs;
        hits_total = n;
        bits_total = b;
    end

    assign bits_new = bits_reg + pos_t'(bits_total);
    assign cnt_new  = cnt_reg + pos_t'(hits_total);
    assign ovf_new  = ovf_reg || (byte_valid && !counted[LANES-1]);

    always_comb
    begin
        if (bits_new == '0 && !ovf_new)
        begin
            status_new = ST_NO_DATA;
        end
        else if (ovf_new)
        begin
            status_new = ST_OVERFLOW;
        end
        else if (bits_new < pos_t'(used_len))
        begin
            status_new = ST_TOO_SHORT;
        end
        else if (!found_new)
        begin
            status_new = ST_NOT_FOUND;
        end
        else
        begin
            status_new = ST_OK;
        end
    end

    assign ctrl.emask  = emask;
    assign ctrl.span   = end_of_data && mode && found_new;
    assign ctrl.summ   = end_of_data;
    assign ctrl.status = status_new;
    assign span_start  = prev_new;
    assign span_len    = bits_new - prev_new;
    assign fin_cnt     = cnt_new;
    assign summ_start  = found_new ? first_new : '0;
    assign summ_len    = bits_new;

    always_comb
    begin
        bits_next  = bits_reg;
        ovf_next   = ovf_reg;
        hold_next  = hold_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        if (advance)
        begin
            if (end_of_data)
            begin
                bits_next  = '0;
                ovf_next   = 1'b0;
                hold_next  = '0;
                prev_next  = '0;
                first_next = '0;
                found_next = 1'b0;
                cnt_next   = '0;
            end
            else
            begin
                bits_next  = bits_new;
                ovf_next   = ovf_new;
                hold_next  = hold_new;
                prev_next  = prev_new;
                first_next = first_new;
                found_next = found_new;
                cnt_next   = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= '0;
            prev_reg  <= '0;
            first_reg <= '0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            bits_reg  <= bits_next;
            ovf_reg   <= ovf_next;
            hold_reg  <= hold_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bsps_emit.sv
// Result buffer and output register: sends the records of one merged item one at a time.
`default_nettype none

module bsps_emit #(
    parameter int POSITION_BITS = 36
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        s1_valid,
    input  wire bsps_pkg::batch_ctrl_t                       ctrl_in,
    input  wire logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0] lane_start,
    input  wire logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0] lane_prev,
    input  wire logic [bsps_pkg::LANES-1:0][POSITION_BITS-1:0] lane_cnt,
    input  wire logic [POSITION_BITS-1:0]                    span_start,
    input  wire logic [POSITION_BITS-1:0]                    span_len,
    input  wire logic [POSITION_BITS-1:0]                    fin_cnt,
    input  wire logic [POSITION_BITS-1:0]                    summ_start,
    input  wire logic [POSITION_BITS-1:0]                    summ_len,
    input  wire logic                                        mode,
    input  wire logic [bsps_pkg::LEN_BITS-1:0]               used_len,
    input  wire logic                                        out_stall,
    output logic                                             advance,
    output logic                                             out_valid,
    output logic [1:0]                                       record_kind,
    output logic [POSITION_BITS-1:0]                         start_bit,
    output logic [POSITION_BITS-1:0]                         length_bits,
    output logic [POSITION_BITS-1:0]                         match_count,
    output logic [2:0]                                       status,
    output logic                                             last
);

    import bsps_pkg::*;

    typedef logic [POSITION_BITS-1:0] pos_t;

    batch_ctrl_t bctrl_reg, bctrl_next;
    logic [LANES-1:0][POSITION_BITS-1:0] bstart_reg;
    logic [LANES-1:0][POSITION_BITS-1:0] bprev_reg;
    logic [LANES-1:0][POSITION_BITS-1:0] bcnt_reg;
    pos_t span_start_reg;
    pos_t span_len_reg;
    pos_t fin_cnt_reg;
    pos_t summ_start_reg;
    pos_t summ_len_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] kind_reg;
    pos_t       start_reg;
    pos_t       len_reg;
    pos_t       cnt_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    logic                     busy;
    logic                     out_load;
    logic [LANE_IDX_BITS-1:0] k;
    batch_ctrl_t              after;
    logic                     remains;
    logic [1:0]               r_kind;
    pos_t                     r_start;
    pos_t                     r_len;
    pos_t                     r_cnt;
    logic [2:0]               r_status;

    assign busy     = (bctrl_reg.emask != '0) || bctrl_reg.span || bctrl_reg.summ;
    assign out_load = busy && (!out_valid_reg || !out_stall);

    // lowest pending lane goes first
    always_comb
    begin
        k = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (bctrl_reg.emask[i])
            begin
                k = LANE_IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        after    = bctrl_reg;
        r_kind   = KIND_SUMMARY;
        r_start  = summ_start_reg;
        r_len    = summ_len_reg;
        r_cnt    = fin_cnt_reg;
        r_status = bctrl_reg.status;
        if (bctrl_reg.emask != '0)
        begin
            after.emask[k] = 1'b0;
            r_cnt    = bcnt_reg[k];
            r_status = ST_OK;
            if (mode)
            begin
                r_kind  = KIND_SPAN;
                r_start = bprev_reg[k];
                r_len   = bstart_reg[k] - bprev_reg[k];
            end
            else
            begin
                r_kind  = KIND_MATCH;
                r_start = bstart_reg[k];
                r_len   = pos_t'(used_len);
            end
        end
        else if (bctrl_reg.span)
        begin
            after.span = 1'b0;
            r_kind     = KIND_SPAN;
            r_start    = span_start_reg;
            r_len      = span_len_reg;
            r_status   = ST_OK;
        end
        else
        begin
            after.summ = 1'b0;
        end
        remains = (after.emask != '0) || after.span || after.summ;
    end

    assign advance = s1_valid && (!busy || (out_load && !remains));

    always_comb
    begin
        bctrl_next = bctrl_reg;
        if (advance)
        begin
            bctrl_next = ctrl_in;
        end
        else if (out_load)
        begin
            bctrl_next = after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bctrl_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bctrl_reg     <= bctrl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bstart_reg     <= lane_start;
            bprev_reg      <= lane_prev;
            bcnt_reg       <= lane_cnt;
            span_start_reg <= span_start;
            span_len_reg   <= span_len;
            fin_cnt_reg    <= fin_cnt;
            summ_start_reg <= summ_start;
            summ_len_reg   <= summ_len;
        end
        if (out_load)
        begin
            kind_reg   <= r_kind;
            start_reg  <= r_start;
            len_reg    <= r_len;
            cnt_reg    <= r_cnt;
            status_reg <= r_status;
            last_reg   <= !remains;
        end
    end

    assign out_valid   = out_valid_reg;
    assign record_kind = kind_reg;
    assign start_bit   = start_reg;
    assign length_bits = len_reg;
    assign match_count = cnt_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
